// File: hw/rtl/gdo_pkg.sv
// ============================================================================
// gdo_pkg: shared types, constants and microcode for the date offset unit
// Holds the transaction payload types, the control word format, the program
// ROM and the small calendar helpers used by the datapath.
// ============================================================================
package gdo_pkg;

  // Field widths
  localparam int YEAR_W = 14;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int OFS_W  = 17;
  localparam int CNT_W  = 16;
  localparam int ACC_W  = 24;   // signed day accumulator, covers year 16383 plus offset
  localparam int DC_W   = 23;   // day constant in a control word
  localparam int UPC_W  = 6;    // step counter

  // Calendar constants
  localparam int D400       = 146097;  // days in 400 years
  localparam int D100       = 36524;   // days in an ordinary century
  localparam int D4         = 1461;    // days in an ordinary 4-year span
  localparam int D1         = 365;
  localparam int Y400       = 400;
  localparam int Y100       = 100;
  localparam int Y4         = 4;
  localparam int Y1         = 1;
  localparam int MAX_DAYNUM = 3652058; // 9999-12-31
  localparam int CNT_MAX    = 65535;
  localparam int MON_COUNT  = 12;
  localparam logic [MON_W-1:0] MON_LAST = MON_W'(MON_COUNT - 1);

  // 7209 * 25 == 1 (mod 2^14): y is a multiple of 25 iff y * 7209 mod 2^14 <= 16383 / 25
  localparam int LEAP_INV25 = 7209;
  localparam int MUL25_MAX  = 655;

  // Input transaction
  typedef struct packed {
    logic                     kind;
    logic [YEAR_W-1:0]        year;
    logic [MON_W-1:0]         month;
    logic [DAY_W-1:0]         day;
    logic signed [OFS_W-1:0]  offset;
    logic [YEAR_W-1:0]        other_year;
    logic [MON_W-1:0]         other_month;
    logic [DAY_W-1:0]         other_day;
  } gdo_item_t;

  // Result transaction
  typedef struct packed {
    logic [YEAR_W-1:0] res_year;
    logic [MON_W-1:0]  res_month;
    logic [DAY_W-1:0]  res_day;
    logic [CNT_W-1:0]  day_count;
    logic              out_of_range;
  } gdo_res_t;

  // Sequencer states
  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } gdo_seq_state_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_LOAD,     // load year-1 and day-of-year of the selected date
    OP_ADDLP,    // add the leap day picked up by OP_LOAD
    OP_YSUB,     // years -> days: if yr >= yc then yr -= yc, acc += dc
    OP_SAVE,     // keep the first day number
    OP_DIFF,     // saturated distance between the two day numbers
    OP_OFFSET,   // acc += offset
    OP_SAT,      // clamp acc to the supported span, clear year and month
    OP_DSUB,     // days -> years: if acc >= dc then acc -= dc, yr += yc
    OP_YEAR,     // year count -> calendar year, latch its leap flag
    OP_MSUB,     // peel one month off acc
    OP_DONE      // load the result register
  } gdo_op_t;

  // Jump conditions
  typedef enum logic [1:0] {
    JC_NONE,     // fall through
    JC_TAKEN,    // the compare of this step passed
    JC_KIND1,    // distance transaction
    JC_REDO      // distance transaction, first date done
  } gdo_jc_t;

  // Control word
  typedef struct packed {
    gdo_op_t           op;
    gdo_jc_t           jc;
    logic [UPC_W-1:0]  tgt;
    logic [DC_W-1:0]   dc;
    logic [YEAR_W-1:0] yc;
  } gdo_uword_t;

  // Sequencer to datapath
  typedef struct packed {
    gdo_uword_t uw;
    logic       run;
    logic       load_in;
  } gdo_ctl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic take;
    logic kind;
    logic pass;
  } gdo_sts_t;

  // Entry points of the program
  localparam logic [UPC_W-1:0] UA_LOAD = 6'd0;
  localparam logic [UPC_W-1:0] UA_MSUB = 6'd40;
  localparam logic [UPC_W-1:0] UA_DONE = 6'd41;

  function automatic gdo_uword_t gdo_uw(input gdo_op_t op, input gdo_jc_t jc,
                                        input logic [UPC_W-1:0] tgt,
                                        input int dc, input int yc);
    gdo_uword_t w;
    w.op  = op;
    w.jc  = jc;
    w.tgt = tgt;
    w.dc  = DC_W'(dc);
    w.yc  = YEAR_W'(yc);
    return w;
  endfunction

  // Program ROM. Steps 0..19 convert one date to a day number and run twice
  // for a distance transaction; steps 21..40 add the offset, clamp the sum and turn it into a date.
  function automatic gdo_uword_t gdo_rom(input logic [UPC_W-1:0] a);
    gdo_uword_t w;
    case (a)
      6'd0:  w = gdo_uw(OP_LOAD,   JC_NONE,  UA_LOAD, 0, 0);
      6'd1:  w = gdo_uw(OP_ADDLP,  JC_NONE,  UA_LOAD, 0, 0);
      // whole 400-year blocks, binary search over 6 quotient bits
      6'd2:  w = gdo_uw(OP_YSUB,   JC_NONE,  UA_LOAD, D400 * 32, Y400 * 32);
      6'd3:  w = gdo_uw(OP_YSUB,   JC_NONE,  UA_LOAD, D400 * 16, Y400 * 16);
      6'd4:  w = gdo_uw(OP_YSUB,   JC_NONE,  UA_LOAD, D400 * 8,  Y400 * 8);
      6'd5:  w = gdo_uw(OP_YSUB,   JC_NONE,  UA_LOAD, D400 * 4,  Y400 * 4);
      6'd6:  w = gdo_uw(OP_YSUB,   JC_NONE,  UA_LOAD, D400 * 2,  Y400 * 2);
      6'd7:  w = gdo_uw(OP_YSUB,   JC_NONE,  UA_LOAD, D400,      Y400);
      // centuries, at most three
      6'd8:  w = gdo_uw(OP_YSUB,   JC_NONE,  UA_LOAD, D100,      Y100);
      6'd9:  w = gdo_uw(OP_YSUB,   JC_NONE,  UA_LOAD, D100,      Y100);
      6'd10: w = gdo_uw(OP_YSUB,   JC_NONE,  UA_LOAD, D100,      Y100);
      // 4-year spans, 5 quotient bits
      6'd11: w = gdo_uw(OP_YSUB,   JC_NONE,  UA_LOAD, D4 * 16,   Y4 * 16);
      6'd12: w = gdo_uw(OP_YSUB,   JC_NONE,  UA_LOAD, D4 * 8,    Y4 * 8);
      6'd13: w = gdo_uw(OP_YSUB,   JC_NONE,  UA_LOAD, D4 * 4,    Y4 * 4);
      6'd14: w = gdo_uw(OP_YSUB,   JC_NONE,  UA_LOAD, D4 * 2,    Y4 * 2);
      6'd15: w = gdo_uw(OP_YSUB,   JC_NONE,  UA_LOAD, D4,        Y4);
      // single years, at most three
      6'd16: w = gdo_uw(OP_YSUB,   JC_NONE,  UA_LOAD, D1,        Y1);
      6'd17: w = gdo_uw(OP_YSUB,   JC_NONE,  UA_LOAD, D1,        Y1);
      6'd18: w = gdo_uw(OP_YSUB,   JC_NONE,  UA_LOAD, D1,        Y1);
      6'd19: w = gdo_uw(OP_SAVE,   JC_REDO,  UA_LOAD, 0, 0);
      6'd20: w = gdo_uw(OP_DIFF,   JC_KIND1, UA_DONE, 0, 0);
      6'd21: w = gdo_uw(OP_OFFSET, JC_NONE,  UA_LOAD, 0, 0);
      6'd22: w = gdo_uw(OP_SAT,    JC_NONE,  UA_LOAD, 0, 0);
      // 400-year blocks, 5 quotient bits
      6'd23: w = gdo_uw(OP_DSUB,   JC_NONE,  UA_LOAD, D400 * 16, Y400 * 16);
      6'd24: w = gdo_uw(OP_DSUB,   JC_NONE,  UA_LOAD, D400 * 8,  Y400 * 8);
      6'd25: w = gdo_uw(OP_DSUB,   JC_NONE,  UA_LOAD, D400 * 4,  Y400 * 4);
      6'd26: w = gdo_uw(OP_DSUB,   JC_NONE,  UA_LOAD, D400 * 2,  Y400 * 2);
      6'd27: w = gdo_uw(OP_DSUB,   JC_NONE,  UA_LOAD, D400,      Y400);
      // centuries, capped at three so the last day of a 400-year block stays put
      6'd28: w = gdo_uw(OP_DSUB,   JC_NONE,  UA_LOAD, D100,      Y100);
      6'd29: w = gdo_uw(OP_DSUB,   JC_NONE,  UA_LOAD, D100,      Y100);
      6'd30: w = gdo_uw(OP_DSUB,   JC_NONE,  UA_LOAD, D100,      Y100);
      6'd31: w = gdo_uw(OP_DSUB,   JC_NONE,  UA_LOAD, D4 * 16,   Y4 * 16);
      6'd32: w = gdo_uw(OP_DSUB,   JC_NONE,  UA_LOAD, D4 * 8,    Y4 * 8);
      6'd33: w = gdo_uw(OP_DSUB,   JC_NONE,  UA_LOAD, D4 * 4,    Y4 * 4);
      6'd34: w = gdo_uw(OP_DSUB,   JC_NONE,  UA_LOAD, D4 * 2,    Y4 * 2);
      6'd35: w = gdo_uw(OP_DSUB,   JC_NONE,  UA_LOAD, D4,        Y4);
      // single years, capped at three for Dec 31 of a leap year
      6'd36: w = gdo_uw(OP_DSUB,   JC_NONE,  UA_LOAD, D1,        Y1);
      6'd37: w = gdo_uw(OP_DSUB,   JC_NONE,  UA_LOAD, D1,        Y1);
      6'd38: w = gdo_uw(OP_DSUB,   JC_NONE,  UA_LOAD, D1,        Y1);
      6'd39: w = gdo_uw(OP_YEAR,   JC_NONE,  UA_LOAD, 0, 0);
      6'd40: w = gdo_uw(OP_MSUB,   JC_TAKEN, UA_MSUB, 0, 0);
      6'd41: w = gdo_uw(OP_DONE,   JC_NONE,  UA_LOAD, 0, 0);
      default: w = gdo_uw(OP_DONE, JC_NONE,  UA_LOAD, 0, 0);
    endcase
    return w;
  endfunction

  // Gregorian leap rule: div by 4 and not by 100, or div by 400 (= div by 16 and 25)
  function automatic logic gdo_is_leap(input logic [YEAR_W-1:0] y);
    logic [2*YEAR_W-1:0] prod;
    logic                div25;
    prod  = {{YEAR_W{1'b0}}, y} * (2*YEAR_W)'(LEAP_INV25);
    div25 = prod[YEAR_W-1:0] <= YEAR_W'(MUL25_MAX);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  // Days before the first of month index mi (0 = January), common year
  function automatic logic [8:0] gdo_month_start(input logic [MON_W-1:0] mi);
    logic [8:0] s;
    case (mi)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      default: s = 9'd334;
    endcase
    return s;
  endfunction

  // Length of month index mi
  function automatic logic [DAY_W-1:0] gdo_month_len(input logic [MON_W-1:0] mi,
                                                      input logic leap);
    logic [DAY_W-1:0] n;
    case (mi)
      4'd1:                n = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: n = 5'd30;
      default:             n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

// File: hw/rtl/gdo_in_if.sv
// ============================================================================
// gdo_in_if: input channel of the date offset unit
// Valid/ready channel carrying one date transaction.
// ============================================================================
interface gdo_in_if;
  import gdo_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [YEAR_W-1:0]        year;
  logic [MON_W-1:0]         month;
  logic [DAY_W-1:0]         day;
  logic signed [OFS_W-1:0]  offset;
  logic [YEAR_W-1:0]        other_year;
  logic [MON_W-1:0]         other_month;
  logic [DAY_W-1:0]         other_day;

  modport source (
    output valid, kind, year, month, day, offset, other_year, other_month, other_day,
    input  ready
  );

  modport sink (
    input  valid, kind, year, month, day, offset, other_year, other_month, other_day,
    output ready
  );
endinterface

// File: hw/rtl/gdo_out_if.sv
// ============================================================================
// gdo_out_if: result channel of the date offset unit
// Valid/ready channel carrying one result transaction.
// ============================================================================
interface gdo_out_if;
  import gdo_pkg::*;

  logic              valid;
  logic              ready;
  logic [YEAR_W-1:0] res_year;
  logic [MON_W-1:0]  res_month;
  logic [DAY_W-1:0]  res_day;
  logic [CNT_W-1:0]  day_count;
  logic              out_of_range;

  modport source (
    output valid, res_year, res_month, res_day, day_count, out_of_range,
    input  ready
  );

  modport sink (
    input  valid, res_year, res_month, res_day, day_count, out_of_range,
    output ready
  );
endinterface

// File: hw/rtl/gdo_dpath.sv
// ============================================================================
// gdo_dpath: datapath of the date offset unit
// Accumulator, year register, month index and conditional add/subtract logic,
// steered by the control word of the current step.
// ============================================================================
module gdo_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  gdo_pkg::gdo_ctl_t  ctl,
  input  gdo_pkg::gdo_item_t item,
  output gdo_pkg::gdo_sts_t  sts,
  output gdo_pkg::gdo_res_t  res
);
  import gdo_pkg::*;

  gdo_item_t                item_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  a_r;
  logic [YEAR_W-1:0]        yr_r;
  logic [MON_W-1:0]         mo_r;
  logic                     lp_r;
  logic                     pass_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     ovf_r;
  gdo_res_t                 res_r;

  logic [YEAR_W-1:0]        ysrc, y_cl, yr_inc, leap_yr;
  logic [MON_W-1:0]         msrc, m_cl, mi;
  logic [DAY_W-1:0]         dsrc, mlen;
  logic                     leap_w;
  logic [ACC_W-1:0]         load_acc;
  logic signed [ACC_W-1:0]  dc_s, mlen_s, lp_s, ofs_s;
  logic signed [ACC_W-1:0]  diff_ab, diff_abs;
  logic                     ysub_take, dsub_take, msub_take, take;

  // Date select and clamping of the operand being converted
  always_comb begin
    ysrc = pass_r ? item_r.other_year  : item_r.year;
    msrc = pass_r ? item_r.other_month : item_r.month;
    dsrc = pass_r ? item_r.other_day   : item_r.day;
    y_cl = (ysrc == '0) ? YEAR_W'(1) : ysrc;
    if (msrc == '0) begin
      m_cl = MON_W'(1);
    end else if (msrc > MON_W'(MON_COUNT)) begin
      m_cl = MON_W'(MON_COUNT);
    end else begin
      m_cl = msrc;
    end
    mi       = m_cl - MON_W'(1);
    load_acc = ACC_W'(gdo_month_start(mi)) + ACC_W'(dsrc) - ACC_W'(1);
  end

  // Leap flag: source year on load, result year when the year is finalized
  assign yr_inc  = yr_r + YEAR_W'(1);
  assign leap_yr = (ctl.uw.op == OP_YEAR) ? yr_inc : y_cl;
  assign leap_w  = gdo_is_leap(leap_yr);

  // Compares for the conditional-subtract steps
  assign dc_s      = $signed({1'b0, ctl.uw.dc});
  assign mlen      = gdo_month_len(mo_r, lp_r);
  assign mlen_s    = $signed({{(ACC_W-DAY_W){1'b0}}, mlen});
  assign lp_s      = $signed({{(ACC_W-1){1'b0}}, lp_r});
  assign ofs_s     = ACC_W'($signed(item_r.offset));
  assign ysub_take = yr_r >= ctl.uw.yc;
  assign dsub_take = acc_r >= dc_s;
  assign msub_take = (mo_r != MON_LAST) && (acc_r >= mlen_s);

  // Distance between the saved and the current day number
  assign diff_ab  = a_r - acc_r;
  assign diff_abs = diff_ab[ACC_W-1] ? -diff_ab : diff_ab;

  always_comb begin
    case (ctl.uw.op)
      OP_YSUB: take = ysub_take;
      OP_DSUB: take = dsub_take;
      OP_MSUB: take = msub_take;
      default: take = 1'b0;
    endcase
  end

  assign sts.take = take;
  assign sts.kind = item_r.kind;
  assign sts.pass = pass_r;

  // Item capture and step execution
  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      item_r <= item;
      pass_r <= 1'b0;
    end else if (ctl.run) begin
      case (ctl.uw.op)
        OP_LOAD: begin
          yr_r  <= y_cl - YEAR_W'(1);
          acc_r <= $signed(load_acc);
          lp_r  <= (m_cl > MON_W'(2)) && leap_w;
        end
        OP_ADDLP: begin
          acc_r <= acc_r + lp_s;
        end
        OP_YSUB: begin
          if (ysub_take) begin
            yr_r  <= yr_r - ctl.uw.yc;
            acc_r <= acc_r + dc_s;
          end
        end
        OP_SAVE: begin
          if (!pass_r) begin
            a_r    <= acc_r;
            pass_r <= 1'b1;
          end
        end
        OP_DIFF: begin
          if (diff_abs > $signed(ACC_W'(CNT_MAX))) begin
            cnt_r <= CNT_W'(CNT_MAX);
            ovf_r <= 1'b1;
          end else begin
            cnt_r <= diff_abs[CNT_W-1:0];
            ovf_r <= 1'b0;
          end
        end
        OP_OFFSET: begin
          acc_r <= acc_r + ofs_s;
        end
        OP_SAT: begin
          if (acc_r < 0) begin
            acc_r <= '0;
            ovf_r <= 1'b1;
          end else if (acc_r > $signed(ACC_W'(MAX_DAYNUM))) begin
            acc_r <= $signed(ACC_W'(MAX_DAYNUM));
            ovf_r <= 1'b1;
          end else begin
            ovf_r <= 1'b0;
          end
          yr_r <= '0;
          mo_r <= '0;
        end
        OP_DSUB: begin
          if (dsub_take) begin
            acc_r <= acc_r - dc_s;
            yr_r  <= yr_r + ctl.uw.yc;
          end
        end
        OP_YEAR: begin
          yr_r <= yr_inc;
          lp_r <= leap_w;
        end
        OP_MSUB: begin
          if (msub_take) begin
            acc_r <= acc_r - mlen_s;
            mo_r  <= mo_r + MON_W'(1);
          end
        end
        OP_DONE: begin
          res_r.out_of_range <= ovf_r;
          if (item_r.kind) begin
            res_r.res_year  <= '0;
            res_r.res_month <= '0;
            res_r.res_day   <= '0;
            res_r.day_count <= cnt_r;
          end else begin
            res_r.res_year  <= yr_r;
            res_r.res_month <= mo_r + MON_W'(1);
            res_r.res_day   <= acc_r[DAY_W-1:0] + DAY_W'(1);
            res_r.day_count <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign res = res_r;

  // Month walk never passes December
  a_month_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.run && ctl.uw.op == OP_MSUB) |-> (mo_r <= MON_LAST))
    else $error("month index past December");

  // Day number is clamped before it is split into years
  a_dsub_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.run && ctl.uw.op == OP_DSUB) |-> !acc_r[ACC_W-1])
    else $error("negative day number during year split");

  // Day of year stays non-negative while months are peeled off
  a_msub_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.run && ctl.uw.op == OP_MSUB) |-> !acc_r[ACC_W-1])
    else $error("negative day of year during month walk");

endmodule

// File: hw/rtl/gdo_useq.sv
// ============================================================================
// gdo_useq: microcode sequencer of the date offset unit
// Step counter, program ROM lookup, conditional jumps, input acceptance and
// the valid flag of the result register.
// ============================================================================
module gdo_useq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  gdo_pkg::gdo_sts_t  sts,
  output gdo_pkg::gdo_ctl_t  ctl
);
  import gdo_pkg::*;

  gdo_seq_state_t    state_r, state_nxt;
  logic [UPC_W-1:0]  upc_r, upc_nxt;
  logic              out_valid_r, out_valid_nxt;

  gdo_uword_t        uw;
  logic              in_fire, out_free, hold, run, jump, done_fire;

  assign uw = gdo_rom(upc_r);

  // Next step, handshakes and control to the datapath
  always_comb begin
    in_ready  = rst_n && (state_r == SEQ_IDLE);
    in_fire   = in_valid && in_ready;
    out_free  = !out_valid_r || out_ready;
    hold      = (uw.op == OP_DONE) && !out_free;
    run       = (state_r == SEQ_RUN) && !hold;
    done_fire = run && (uw.op == OP_DONE);

    case (uw.jc)
      JC_NONE:  jump = 1'b0;
      JC_TAKEN: jump = sts.take;
      JC_KIND1: jump = sts.kind;
      JC_REDO:  jump = sts.kind && !sts.pass;
      default:  jump = 1'b0;
    endcase

    state_nxt = state_r;
    upc_nxt   = upc_r;
    case (state_r)
      SEQ_IDLE: begin
        if (in_fire) begin
          state_nxt = SEQ_RUN;
          upc_nxt   = UA_LOAD;
        end
      end
      SEQ_RUN: begin
        if (done_fire) begin
          state_nxt = SEQ_IDLE;
        end else if (run) begin
          upc_nxt = jump ? uw.tgt : upc_r + UPC_W'(1);
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase

    // Result register: filled on the last step, emptied by the sink
    if (done_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    ctl.uw      = uw;
    ctl.run     = run;
    ctl.load_in = in_fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      upc_r       <= UA_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      upc_r       <= upc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A new transaction starts the program at its first step
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == SEQ_RUN && upc_r == UA_LOAD))
    else $error("program did not start at first step");

  // Step counter stays inside the program
  a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SEQ_RUN) |-> (upc_r <= UA_DONE))
    else $error("step counter outside program");

  // Finishing a transaction fills the result register and frees the input
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_fire |=> (out_valid_r && state_r == SEQ_IDLE))
    else $error("result not posted on last step");

endmodule

// File: hw/rtl/gregorian_date_offset_top.sv
// ============================================================================
// gregorian_date_offset_top: Gregorian date offset and distance unit
// Shifts a date by a signed day count, or gives the day distance between two
// dates, using a microcoded sequencer over a conditional-subtract datapath.
// ============================================================================
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-----------------------------------
//  in_if    | sink      | valid / ready       | kind, date, offset, second date
//  out_if   | source    | valid / ready       | date, day_count, out_of_range
//
//  An offset transaction runs the whole program, repeating the month-walk step
//  for each month peeled off the result; a distance transaction converts both
//  dates, then jumps to the last step; one quotient bit or one month per step.
//  Reset is synchronous and active low; it clears the sequencer and the
//  result valid flag. A new transaction is accepted once the program ends.
//  Output back-pressure stalls the program on its last step only.
//
module gregorian_date_offset_top (
  input  logic   clk,
  input  logic   rst_n,
  gdo_in_if.sink   in_if,
  gdo_out_if.source out_if
);
  import gdo_pkg::*;

  gdo_item_t item;
  gdo_ctl_t  ctl;
  gdo_sts_t  sts;
  gdo_res_t  res;

  // Pack the input transaction
  always_comb begin
    item.kind        = in_if.kind;
    item.year        = in_if.year;
    item.month       = in_if.month;
    item.day         = in_if.day;
    item.offset      = in_if.offset;
    item.other_year  = in_if.other_year;
    item.other_month = in_if.other_month;
    item.other_day   = in_if.other_day;
  end

  gdo_useq u_useq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  gdo_dpath u_dpath (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .item  (item),
    .sts   (sts),
    .res   (res)
  );

  // Unpack the result transaction
  assign out_if.res_year     = res.res_year;
  assign out_if.res_month    = res.res_month;
  assign out_if.res_day      = res.res_day;
  assign out_if.day_count    = res.day_count;
  assign out_if.out_of_range = res.out_of_range;

endmodule
